// ----- design/lvaq_pkg.sv -----
package lvaq_pkg;

   // Number of low breaths that confirm the alarm, and the counter width it needs.
   localparam int unsigned CONFIRM_BREATHS = 3;
   localparam int unsigned COUNT_W = $clog2(CONFIRM_BREATHS + 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CONFIRM_BREATHS);

   // Alarm state codes as they arrive on the request word.
   typedef enum logic [2:0] {
      ALM_FALSE     = 3'd0,
      ALM_DETECTED  = 3'd1,
      ALM_TRUE      = 3'd2,
      ALM_DISPLAYED = 3'd3,
      ALM_CANCELLED = 3'd4
   } alarm_code_type;

   // Alarm state codes as they leave on the response word.
   localparam logic [1:0] NEW_FALSE    = 2'd0;
   localparam logic [1:0] NEW_DETECTED = 2'd1;
   localparam logic [1:0] NEW_TRUE     = 2'd2;

   // Event codes.
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_ALARM = 2'd1;
   localparam logic [1:0] EV_END   = 2'd2;

   // Breath phase codes.
   localparam logic [1:0] PH_OTHER     = 2'd0;
   localparam logic [1:0] PH_EXHALE    = 2'd1;
   localparam logic [1:0] PH_INSP_CTRL = 2'd2;
   localparam logic [1:0] PH_INSP_TRIG = 2'd3;

   // Control register indexes.
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_DISABLE   = 1'b1;

   localparam int unsigned CSR_DATA_W = 16;

   typedef struct packed {
      logic [15:0] measured_volume;
      logic [2:0]  alarm_state;
      logic [2:0]  disconnect_state;
      logic [1:0]  breath_phase;
   } req_word_type;

   typedef struct packed {
      logic       write_state;
      logic [1:0] new_state;
      logic [1:0] event_code;
      logic       priority_set;
      logic       priority_clear;
      logic       error_flag;
   } rsp_word_type;

   // Handshake status passed from the output stage back to the pipeline.
   typedef struct packed {
      logic advance;
      logic fire;
   } stage_ctl_type;

endpackage

// ----- design/lvaq_if.sv -----
interface lvaq_req_if;
   import lvaq_pkg::*;

   logic        valid;
   logic        ready;
   logic [15:0] measured_volume;
   logic [2:0]  alarm_state;
   logic [2:0]  disconnect_state;
   logic [1:0]  breath_phase;

   modport source (
      output valid, measured_volume, alarm_state, disconnect_state, breath_phase,
      input  ready
   );

   modport sink (
      input  valid, measured_volume, alarm_state, disconnect_state, breath_phase,
      output ready
   );
endinterface

interface lvaq_rsp_if;
   import lvaq_pkg::*;

   logic       valid;
   logic       ready;
   logic       write_state;
   logic [1:0] new_state;
   logic [1:0] event_code;
   logic       priority_set;
   logic       priority_clear;
   logic       error_flag;

   modport source (
      output valid, write_state, new_state, event_code, priority_set, priority_clear,
             error_flag,
      input  ready
   );

   modport sink (
      input  valid, write_state, new_state, event_code, priority_set, priority_clear,
             error_flag,
      output ready
   );
endinterface

// ----- design/lvaq_in_reg.sv -----
module lvaq_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lvaq_pkg::req_word_type req_word,
   input  lvaq_pkg::stage_ctl_type ctl,
   output logic                  held_valid,
   output lvaq_pkg::req_word_type held_word
);
   import lvaq_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;

   // The register takes a new word when it is empty or its word moves on.
   assign req_ready = !valid_ff || ctl.advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

// ----- design/lvaq_qualify.sv -----
module lvaq_qualify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic                    csr_index,
   input  logic [lvaq_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  lvaq_pkg::req_word_type  word,
   input  lvaq_pkg::stage_ctl_type ctl,
   output lvaq_pkg::rsp_word_type  result
);
   import lvaq_pkg::*;

   logic [15:0]        threshold_ff;
   logic               disabled_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               hold_ff;
   logic               hold_in;
   logic [1:0]         phase_ff;

   logic               low;
   logic               selected;
   logic               release_alarm;
   logic               count_step;
   logic [COUNT_W-1:0] count_step_val;
   logic               hold_step;
   logic               breath_start;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         disabled_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[15:0];
            CSR_DISABLE:   disabled_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Conditions shared by the alarm states.
   assign low           = word.measured_volume < threshold_ff;
   assign selected      = !disabled_ff;
   assign release_alarm = !low || !selected ||
                          (word.disconnect_state >= 3'(ALM_TRUE));

   // A low breath is counted once per breath, up to the confirm count.
   assign count_step     = (count_ff < COUNT_FULL) && !hold_ff;
   assign count_step_val = count_step ? count_ff + 1'b1 : count_ff;
   assign hold_step      = hold_ff || count_step;

   // An inspiration right after exhalation opens a new breath.
   assign breath_start = (phase_ff == PH_EXHALE) &&
                         ((word.breath_phase == PH_INSP_CTRL) ||
                          (word.breath_phase == PH_INSP_TRIG));

   // Alarm state handling and next counter values.
   always_comb begin
      result   = '0;
      count_in = count_ff;
      hold_in  = hold_ff;
      unique case (word.alarm_state)
         ALM_FALSE: begin
            if (low && selected && (word.disconnect_state <= 3'(ALM_DETECTED))) begin
               result.write_state = 1'b1;
               result.new_state   = NEW_DETECTED;
               count_in           = '0;
            end
         end
         ALM_DETECTED: begin
            count_in = count_step_val;
            hold_in  = hold_step;
            if (release_alarm) begin
               result.write_state = 1'b1;
               result.new_state   = NEW_FALSE;
               count_in           = '0;
            end else if (count_step_val == COUNT_FULL) begin
               result.write_state  = 1'b1;
               result.new_state    = NEW_TRUE;
               result.event_code   = EV_ALARM;
               result.priority_set = 1'b1;
            end
         end
         ALM_TRUE: begin
         end
         ALM_DISPLAYED: begin
            if (release_alarm) begin
               result.write_state    = 1'b1;
               result.new_state      = NEW_FALSE;
               result.event_code     = EV_END;
               result.priority_clear = 1'b1;
               count_in              = '0;
            end
         end
         default: begin
            result.error_flag = 1'b1;
         end
      endcase
      if (breath_start) begin
         hold_in = 1'b0;
      end
   end

   // Breath state advances with each word that moves to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hold_ff  <= 1'b0;
         phase_ff <= PH_OTHER;
      end else if (ctl.fire) begin
         count_ff <= count_in;
         hold_ff  <= hold_in;
         phase_ff <= word.breath_phase;
      end
   end

endmodule

// ----- design/lvaq_out_reg.sv -----
module lvaq_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    held_valid,
   input  lvaq_pkg::rsp_word_type  result,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output lvaq_pkg::rsp_word_type  rsp_word,
   output lvaq_pkg::stage_ctl_type ctl
);
   import lvaq_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // The output register frees up when empty or when its word is taken.
   assign ctl.advance = !valid_ff || rsp_ready;
   assign ctl.fire    = held_valid && ctl.advance;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.advance) begin
         valid_in = held_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ----- design/low_volume_alarm_qualifier.sv -----
// Low volume alarm qualifier. Each request word carries one periodic tick: the
// measured exhaled volume, the current low volume alarm state, the disconnection
// alarm state and the breath phase. The block counts low breaths (one per breath,
// up to three) and answers every tick with one response word: a new alarm state
// to store with its write flag, a start or end event, set or clear of medium
// priority bit 2, and an error flag for a cancelled or unknown alarm state. The
// block takes one word per clock cycle unless stalled; each word goes through
// the input register, then the output register, with the qualification logic
// and breath counter update between them. The user must write the threshold and
// disable bit via the csr port only while no word is in flight (unenforced).
module low_volume_alarm_qualifier (
   input  logic                 clock,
   input  logic                 reset,
   lvaq_req_if.sink             req,
   lvaq_rsp_if.source           rsp,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [lvaq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lvaq_pkg::*;

   req_word_type  req_word;
   req_word_type  held_word;
   logic          held_valid;
   rsp_word_type  result;
   rsp_word_type  rsp_word;
   stage_ctl_type ctl;

   // Gather the request fields into one word.
   assign req_word.measured_volume  = req.measured_volume;
   assign req_word.alarm_state      = req.alarm_state;
   assign req_word.disconnect_state = req.disconnect_state;
   assign req_word.breath_phase     = req.breath_phase;

   lvaq_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_word   (req_word),
      .ctl        (ctl),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   lvaq_qualify u_qualify (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .word         (held_word),
      .ctl          (ctl),
      .result       (result)
   );

   lvaq_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .result     (result),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (rsp.valid),
      .rsp_word   (rsp_word),
      .ctl        (ctl)
   );

   // Spread the response word over the channel fields.
   assign rsp.write_state    = rsp_word.write_state;
   assign rsp.new_state      = rsp_word.new_state;
   assign rsp.event_code     = rsp_word.event_code;
   assign rsp.priority_set   = rsp_word.priority_set;
   assign rsp.priority_clear = rsp_word.priority_clear;
   assign rsp.error_flag     = rsp_word.error_flag;

endmodule

// ----- design/lvaq_checker.sv -----
module lvaq_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       write_state,
   input logic [1:0] new_state,
   input logic [1:0] event_code,
   input logic       priority_set,
   input logic       priority_clear,
   input logic       error_flag
);
   import lvaq_pkg::*;

   // A word that is not written carries the false code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !write_state) |-> (new_state == NEW_FALSE))
      else $error("new_state set without write_state");

   // An error word changes nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && error_flag) |->
         (!write_state && (event_code == EV_NONE) && !priority_set && !priority_clear))
      else $error("error word carries an action");

   // Setting the priority bit goes with the alarm event and the true state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && priority_set) |->
         (write_state && (new_state == NEW_TRUE) && (event_code == EV_ALARM)))
      else $error("priority set without alarm confirmation");

   // Clearing the priority bit goes with the end event and the false state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && priority_clear) |->
         (write_state && (new_state == NEW_FALSE) && (event_code == EV_END)))
      else $error("priority clear without alarm end");

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(write_state) && $stable(new_state) &&
          $stable(event_code) && $stable(error_flag)))
      else $error("stalled response word changed");

endmodule

bind low_volume_alarm_qualifier lvaq_checker u_lvaq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .write_state    (rsp.write_state),
   .new_state      (rsp.new_state),
   .event_code     (rsp.event_code),
   .priority_set   (rsp.priority_set),
   .priority_clear (rsp.priority_clear),
   .error_flag     (rsp.error_flag)
);

// ----- tb/low_volume_alarm_qualifier_test.sv -----
`timescale 1ns / 100ps

module low_volume_alarm_qualifier_test;
   import lvaq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 4;

   // Alarm codes past cancelled are invalid on the request word.
   localparam logic [2:0] ALM_INVALID_FIRST = ALM_CANCELLED + 3'd1;
   localparam logic [2:0] ALM_INVALID_LAST  = '1;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lvaq_req_if req_ch ();
   lvaq_rsp_if rsp_ch ();

   low_volume_alarm_qualifier dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Words waiting to be sent, and responses the qualifier is expected to give.
   req_word_type pending_words[$];
   rsp_word_type expected_rsps[$];
   req_word_type on_wire;

   // Our own copy of the control registers and of the breath tracking state.
   logic [15:0]        thr_setting = '0;
   logic               alarm_off = 1'b0;
   logic [COUNT_W-1:0] low_breaths = '0;
   logic               breath_counted = 1'b0;
   logic [1:0]         prev_phase = PH_OTHER;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int queued_words = 0;
   int checked_words = 0;
   int mismatches = 0;
   int cycle_count = 0;

   always #10 clock = ~clock;

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Qualify one tick and advance the breath tracking state.
   function automatic rsp_word_type qualify_tick(req_word_type w);
      rsp_word_type r;
      logic is_low;
      logic selected;
      logic release_alarm;
      r = '0;
      is_low = w.measured_volume < thr_setting;
      selected = !alarm_off;
      release_alarm = !is_low || !selected || w.disconnect_state >= ALM_TRUE;
      case (w.alarm_state)
         ALM_FALSE: begin
            if (is_low && selected && w.disconnect_state <= ALM_DETECTED) begin
               r.write_state = 1'b1;
               r.new_state = NEW_DETECTED;
               low_breaths = '0;
            end
         end
         ALM_DETECTED: begin
            if (low_breaths < COUNT_FULL && !breath_counted) begin
               low_breaths = low_breaths + 1'b1;
               breath_counted = 1'b1;
            end
            if (release_alarm) begin
               r.write_state = 1'b1;
               r.new_state = NEW_FALSE;
               low_breaths = '0;
            end else if (low_breaths == COUNT_FULL) begin
               r.write_state = 1'b1;
               r.new_state = NEW_TRUE;
               r.event_code = EV_ALARM;
               r.priority_set = 1'b1;
            end
         end
         ALM_TRUE: begin
            // The display unit moves the alarm on; nothing to do here.
         end
         ALM_DISPLAYED: begin
            if (release_alarm) begin
               r.write_state = 1'b1;
               r.new_state = NEW_FALSE;
               r.priority_clear = 1'b1;
               r.event_code = EV_END;
               low_breaths = '0;
            end
         end
         default: begin
            r.error_flag = 1'b1;
         end
      endcase
      // A new breath starts when exhalation turns into either inspiration.
      if (prev_phase == PH_EXHALE &&
          (w.breath_phase == PH_INSP_CTRL || w.breath_phase == PH_INSP_TRIG)) begin
         breath_counted = 1'b0;
      end
      prev_phase = w.breath_phase;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(string field, int got, int want);
      if (got != want) begin
         report_mismatch($sformatf("response word %0d, %s is %0d, expected %0d",
                                   checked_words, field, got, want));
      end
   endtask

   task automatic add_word(logic [15:0] vol, logic [2:0] st, logic [2:0] disc,
                           logic [1:0] ph);
      req_word_type w;
      w.measured_volume = vol;
      w.alarm_state = st;
      w.disconnect_state = disc;
      w.breath_phase = ph;
      pending_words.push_back(w);
      queued_words++;
   endtask

   // A volume below a nonzero threshold when asked for one, otherwise at or above it.
   function automatic logic [15:0] pick_volume(bit want_low);
      if (want_low && thr_setting != 0) begin
         return 16'($urandom_range(thr_setting - 1));
      end
      if (want_low) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(16'hFFFF, thr_setting));
   endfunction

   // Mostly a quiet disconnection alarm, now and then one that releases.
   function automatic logic [2:0] pick_disc();
      if (chance(95)) begin
         return 3'($urandom_range(ALM_DETECTED));
      end
      return 3'($urandom_range(ALM_INVALID_LAST, ALM_TRUE));
   endfunction

   function automatic logic [1:0] pick_insp();
      return chance(50) ? PH_INSP_CTRL : PH_INSP_TRIG;
   endfunction

   // One alarm episode as the alarm store would walk it: false, detected over
   // several breaths, true, displayed, and finally a release.
   task automatic queue_episode();
      add_word(pick_volume(chance(90)), ALM_FALSE, pick_disc(), 2'($urandom_range(3)));
      repeat ($urandom_range(5, 1)) begin
         repeat ($urandom_range(3, 1)) begin
            add_word(pick_volume(chance(95)), ALM_DETECTED, pick_disc(), PH_EXHALE);
         end
         repeat ($urandom_range(2, 1)) begin
            add_word(pick_volume(chance(95)), ALM_DETECTED, pick_disc(), pick_insp());
         end
      end
      repeat ($urandom_range(3, 1)) begin
         add_word(pick_volume(chance(50)), ALM_TRUE, pick_disc(), 2'($urandom_range(3)));
      end
      repeat ($urandom_range(4, 0)) begin
         add_word(pick_volume(1'b1), ALM_DISPLAYED, 3'($urandom_range(ALM_DETECTED)),
                  2'($urandom_range(3)));
      end
      if (chance(70)) begin
         add_word(pick_volume(1'b0), ALM_DISPLAYED, 3'($urandom_range(ALM_DETECTED)),
                  2'($urandom_range(3)));
      end else begin
         add_word(pick_volume(1'b1), ALM_DISPLAYED,
                  3'($urandom_range(ALM_INVALID_LAST, ALM_TRUE)), 2'($urandom_range(3)));
      end
   endtask

   task automatic queue_random(int n);
      int stop_at;
      stop_at = queued_words + n;
      while (queued_words < stop_at) begin
         if (chance(75)) begin
            queue_episode();
         end else begin
            add_word(16'($urandom), 3'($urandom_range(7)), 3'($urandom_range(7)),
                     2'($urandom_range(3)));
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_ch.valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_THRESHOLD) begin
         thr_setting = data;
      end else begin
         alarm_off = data[0];
      end
   endtask

   task automatic start_phase(logic [15:0] thr, logic dis, int send_pct, int stall);
      wait_idle();
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_DISABLE, CSR_DATA_W'(dis));
      @(negedge clock);
      send_idle_pct = send_pct;
      stall_pct = stall;
   endtask

   // Request driver: holds a word until it is taken, predicts it when taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(qualify_tick(on_wire));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = pending_words.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.measured_volume <= on_wire.measured_volume;
               req_ch.alarm_state <= on_wire.alarm_state;
               req_ch.disconnect_state <= on_wire.disconnect_state;
               req_ch.breath_phase <= on_wire.breath_phase;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each taken word against the oldest expectation.
   always @(posedge clock) begin : response_monitor
      rsp_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            checked_words++;
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("response word %0d arrived with nothing expected",
                                         checked_words));
            end else begin
               want = expected_rsps.pop_front();
               check_field("write_state", rsp_ch.write_state, want.write_state);
               check_field("new_state", rsp_ch.new_state, want.new_state);
               check_field("event_code", rsp_ch.event_code, want.event_code);
               check_field("priority_set", rsp_ch.priority_set, want.priority_set);
               check_field("priority_clear", rsp_ch.priority_clear, want.priority_clear);
               check_field("error_flag", rsp_ch.error_flag, want.error_flag);
            end
         end
         rsp_ch.ready <= $urandom_range(99) >= stall_pct;
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.measured_volume = '0;
      req_ch.alarm_state = ALM_FALSE;
      req_ch.disconnect_state = ALM_FALSE;
      req_ch.breath_phase = PH_OTHER;
      rsp_ch.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every stage, the error codes and the releases.
      start_phase(16'h8000, 1'b0, 0, 0);
      add_word(16'h0000, ALM_FALSE, ALM_FALSE, PH_OTHER);
      add_word(16'hFFFF, ALM_FALSE, ALM_FALSE, PH_OTHER);
      add_word(16'h7FFF, ALM_DETECTED, ALM_DETECTED, PH_EXHALE);
      add_word(16'h0000, ALM_DETECTED, ALM_FALSE, PH_INSP_CTRL);
      add_word(16'd100, ALM_DETECTED, ALM_FALSE, PH_EXHALE);
      add_word(16'd100, ALM_DETECTED, ALM_FALSE, PH_INSP_TRIG);
      add_word(16'd100, ALM_DETECTED, ALM_FALSE, PH_EXHALE);
      // A full count held in detected repeats the true write every tick.
      add_word(16'd100, ALM_DETECTED, ALM_DETECTED, PH_EXHALE);
      add_word(16'd100, ALM_TRUE, ALM_FALSE, PH_INSP_TRIG);
      add_word(16'd100, ALM_DISPLAYED, ALM_FALSE, PH_EXHALE);
      add_word(16'h8000, ALM_DISPLAYED, ALM_FALSE, PH_INSP_CTRL);
      add_word(16'h0000, ALM_CANCELLED, ALM_FALSE, PH_OTHER);
      add_word(16'h0000, ALM_INVALID_FIRST, ALM_FALSE, PH_EXHALE);
      add_word(16'hFFFF, ALM_INVALID_LAST, ALM_CANCELLED, PH_INSP_TRIG);
      add_word(16'h0000, ALM_FALSE, ALM_TRUE, PH_OTHER);
      add_word(16'h0000, ALM_FALSE, ALM_DETECTED, PH_EXHALE);
      // Disconnection codes past cancelled compare as at least true.
      add_word(16'h0000, ALM_DETECTED, ALM_INVALID_FIRST, PH_EXHALE);
      add_word(16'h0000, ALM_DISPLAYED, ALM_INVALID_LAST, PH_INSP_CTRL);
      add_word(16'h0000, ALM_DETECTED, ALM_CANCELLED, PH_OTHER);
      add_word(16'h0000, ALM_DISPLAYED, ALM_DISPLAYED, PH_EXHALE);
      add_word(16'hFFFF, ALM_DETECTED, ALM_FALSE, PH_INSP_TRIG);

      // Random phases over the threshold range, the disable bit, idling and response stalls.
      start_phase(16'd1000, 1'b0, 0, 0);
      queue_random(160);
      start_phase(16'hFFFF, 1'b0, 55, 0);
      queue_random(160);
      start_phase(16'h0000, 1'b0, 0, 55);
      queue_random(160);
      start_phase(16'd40000, 1'b1, 29, 29);
      queue_random(160);
      start_phase(16'($urandom_range(16'hFFFE, 1)), 1'b0, 29, 29);
      queue_random(160);
      start_phase(16'd20000, 1'b0, 0, 0);
      queue_random(150);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/lvaq_pkg.sv
design/lvaq_if.sv
design/lvaq_in_reg.sv
design/lvaq_qualify.sv
design/lvaq_out_reg.sv
design/low_volume_alarm_qualifier.sv
design/lvaq_checker.sv
tb/low_volume_alarm_qualifier_test.sv
